FILE: hdl/assert_macros.svh
// Assertion macros shared by the archive header locator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, disabled in reset.
`define AHL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, disabled in reset.
`define AHL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

FILE: hdl/ahl_pkg.sv
// Shared types and constants for the archive header locator.
// Used by ahl_scan, archive_header_locator and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ahl_pkg;

    // Number of earlier bytes kept for the twelve-byte header test.
    localparam int unsigned WinDepth     = 11;
    localparam int unsigned FillBits     = 4;
    localparam int unsigned PositionBits = 32;
    localparam int unsigned CfgIdxBits   = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxBits-1:0] CfgSignature = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgMinOffset = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgCountLim  = 2'd2;

    // Register values after reset.
    localparam logic [31:0] SignatureReset = 32'h584D_5044;
    localparam logic [31:0] MinOffsetReset = 32'h0000_0030;
    localparam logic [31:0] CountLimReset  = 32'h0100_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] header_offset;
        logic [31:0] data_offset_word;
        logic [31:0] file_count_word;
    } t_out_item;

    // Header test settings handed to the scanner.
    typedef struct packed {
        logic [31:0] signature_bytes;
        logic [31:0] min_data_offset;
        logic [31:0] file_count_limit;
    } t_cfg;

    // Result produced in the cycle a byte is accepted.
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_scan_result;

endpackage

`default_nettype wire

FILE: hdl/ahl_scan.sv
// Sliding-window scanner: keeps the last eleven bytes and the stream position,
// tests each accepted byte for a header end. Depends on ahl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ahl_scan #(
    parameter int unsigned POSITION_BITS = ahl_pkg::PositionBits
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire ahl_pkg::t_in_item     i_item,
    input  wire ahl_pkg::t_cfg         i_cfg,
    output ahl_pkg::t_scan_result      o_result
);

    localparam int unsigned OfsWide = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam logic [ahl_pkg::FillBits-1:0] FillFull = ahl_pkg::FillBits'(ahl_pkg::WinDepth);

    logic [7:0]                    r_win [ahl_pkg::WinDepth];
    logic [ahl_pkg::FillBits-1:0]  r_fill;
    logic [POSITION_BITS-1:0]      r_pos;
    logic                          r_matched;

    logic [31:0]                   sig_word;
    logic [31:0]                   dofs_word;
    logic [31:0]                   cnt_word;
    logic                          hit;
    logic [POSITION_BITS-1:0]      pos_diff;
    logic [OfsWide-1:0]            pos_diff_ext;

    // Assemble the three little-endian words that end at the current byte.
    assign sig_word  = {r_win[3], r_win[2], r_win[1], r_win[0]};
    assign dofs_word = {r_win[7], r_win[6], r_win[5], r_win[4]};
    assign cnt_word  = {i_item.data_byte, r_win[10], r_win[9], r_win[8]};

    // Header test; it only counts once the window holds eleven bytes.
    assign hit = (r_fill == FillFull)
              && (sig_word == i_cfg.signature_bytes)
              && (dofs_word >= i_cfg.min_data_offset)
              && (cnt_word != 32'd0)
              && (cnt_word < i_cfg.file_count_limit);

    // Header start is eleven bytes before the current one.
    assign pos_diff     = r_pos - POSITION_BITS'(ahl_pkg::WinDepth);
    assign pos_diff_ext = OfsWide'(pos_diff);

    // Result for this transaction: found header, or not-found at stream end.
    always_comb begin
        o_result.valid = i_accept && !r_matched && (hit || i_item.last_byte);
        if (hit) begin
            o_result.item.found            = 1'b1;
            o_result.item.header_offset    = pos_diff_ext[31:0];
            o_result.item.data_offset_word = dofs_word;
            o_result.item.file_count_word  = cnt_word;
        end else begin
            o_result.item = '0;
        end
    end

    // Window shift register; read only while the fill count says it is full.
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_matched && !hit) begin
            for (int i = 0; i < int'(ahl_pkg::WinDepth) - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[ahl_pkg::WinDepth-1] <= i_item.data_byte;
        end
    end

    // Stream control state: fill count, saturating position, match flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_fill    <= '0;
            r_pos     <= '0;
            r_matched <= 1'b0;
        end else if (i_accept && !r_matched) begin
            if (hit) begin
                r_matched <= 1'b1;
            end else begin
                if (r_fill != FillFull) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_pos != '1) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // A match can only be taken on a full window, which then stays frozen.
    `AHL_ASSERT_IMP(a_matched_full, i_clk, i_rst_n, r_matched, r_fill == FillFull)
    // Before the window fills, the position counts the same bytes.
    `AHL_ASSERT_IMP(a_pos_tracks_fill, i_clk, i_rst_n, r_fill != FillFull,
        r_pos == POSITION_BITS'(r_fill))
    // The last byte of a stream always leaves the scanner cleared.
    `AHL_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, i_accept && i_item.last_byte,
        r_fill == '0 && r_pos == '0 && !r_matched)

endmodule

`default_nettype wire

FILE: hdl/archive_header_locator.sv
// Top level of the archive header locator: configuration registers, scanner
// and a two-entry output stage. Depends on ahl_pkg, ahl_scan and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The locator takes one stream byte per clock cycle and tests, at every byte,
// whether the twelve bytes ending there form a valid header: the configured
// signature, a data offset word of at least the minimum, and a nonzero file
// count below the limit. It returns one result per stream: the first header
// found (start offset and both words), or a not-found result on the last byte.
// A result leaves through an output register; a skid register behind it lets
// the input keep flowing while a result waits, and the input stalls only when
// both hold a result. Sustained rate is one byte per cycle while the input is
// not stalled, set by the window shift and compare on each accepted byte.
// Configuration writes take effect in the next cycle and should be made while
// no stream is in flight; there is no clearing pass after reset.
module archive_header_locator #(
    parameter int unsigned POSITION_BITS = ahl_pkg::PositionBits
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Byte input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire ahl_pkg::t_in_item               i_in_data,
    // Result output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output ahl_pkg::t_out_item                   o_out_data,
    // Configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [ahl_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);

    ahl_pkg::t_cfg          r_cfg;
    ahl_pkg::t_scan_result  scan_res;
    ahl_pkg::t_out_item     r_out;
    ahl_pkg::t_out_item     r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic                   in_accept;
    logic                   out_take;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signature_bytes  <= ahl_pkg::SignatureReset;
            r_cfg.min_data_offset  <= ahl_pkg::MinOffsetReset;
            r_cfg.file_count_limit <= ahl_pkg::CountLimReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ahl_pkg::CfgSignature: r_cfg.signature_bytes  <= i_cfg_data;
                ahl_pkg::CfgMinOffset: r_cfg.min_data_offset  <= i_cfg_data;
                ahl_pkg::CfgCountLim:  r_cfg.file_count_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ahl_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (scan_res)
    );

    // Output register with skid entry. The skid only fills when a new result
    // arrives while the output register holds one that is not being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (scan_res.valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= scan_res.item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= scan_res.item;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // The skid entry is never occupied ahead of the output register.
    `AHL_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // A result from the scanner is never produced while the input is stalled.
    `AHL_ASSERT_IMP(a_no_result_in_stall, i_clk, i_rst_n, r_skid_valid, !scan_res.valid)

endmodule

`default_nettype wire

FILE: tb/sv/tb_archive_header_locator.sv
// Self-checking testbench for the archive header locator.
// Depends on ahl_pkg and archive_header_locator; drives bytes, checks each result
// against an in-bench prediction of the header search or a directed table entry.
`timescale 1ns / 1ps

module tb_archive_header_locator;

    import ahl_pkg::*;

    // The block runs with its default position width.
    localparam int unsigned PosBits     = PositionBits;
    localparam logic [63:0] PosMax      = (64'd1 << PosBits) - 64'd1;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned HoldCycles  = 80;
    localparam int unsigned QuietLimit  = 2000;
    localparam int unsigned RoundItems  = 55;
    localparam int unsigned ReportCap   = 100;
    localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

    // Where a directed row takes its expected result from.
    localparam logic ByModel = 1'b0;
    localparam logic ByTable = 1'b1;
    localparam t_out_item NoResult = '0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       from_table;
        t_out_item  result;
    } t_dir_row;

    // Directed streams under the reset register values (signature bytes 44 50 4D 58).
    localparam t_dir_row DirTable [27] = '{
        // One-byte stream: too short to match, so not found.
        '{8'h00, 1'b1, ByTable, '{1'b0, 32'h0, 32'h0, 32'h0}},
        // Header at offset 0 with the minimum data offset and a count of one.
        '{8'h44, 1'b0, ByModel, NoResult},
        '{8'h50, 1'b0, ByModel, NoResult},
        '{8'h4D, 1'b0, ByModel, NoResult},
        '{8'h58, 1'b0, ByModel, NoResult},
        '{8'h30, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByModel, NoResult},
        '{8'h01, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b0, ByTable, '{1'b1, 32'h0, 32'h30, 32'h1}},
        // Bytes after a match are ignored; the last one only clears the stream.
        '{8'hFF, 1'b1, ByModel, NoResult},
        // Header at offset 1, largest words, matched on the last byte.
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'h44, 1'b0, ByModel, NoResult},
        '{8'h50, 1'b0, ByModel, NoResult},
        '{8'h4D, 1'b0, ByModel, NoResult},
        '{8'h58, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'hFF, 1'b0, ByModel, NoResult},
        '{8'h00, 1'b1, ByTable, '{1'b1, 32'h1, 32'hFFFF_FFFF, 32'h00FF_FFFF}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CfgIdxBits-1:0] i_cfg_index;
    logic [31:0]           i_cfg_data;

    // Register values as the bench believes the block holds them.
    logic [31:0] sig_cfg     = SignatureReset;
    logic [31:0] min_ofs_cfg = MinOffsetReset;
    logic [31:0] cnt_lim_cfg = CountLimReset;

    // Predicted scanner state.
    logic [7:0]  scan_win [WinDepth];
    int unsigned scan_fill = 0;
    logic [63:0] scan_pos  = '0;
    logic        scan_done = 1'b0;

    t_out_item   locate_results_due [$];
    t_in_item    stream_q [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned round_items    = 0;
    logic        hold_req       = 1'b0;
    logic        row_from_table = ByModel;
    t_out_item   row_result     = '0;

    archive_header_locator #(
        .POSITION_BITS(PosBits)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the predicted scanner by one byte; hit is set when a result is due.
    function automatic void locate_step(input t_in_item b, output logic hit,
                                        output t_out_item res);
        logic [31:0] sig;
        logic [31:0] ofs;
        logic [31:0] cnt;
        hit = 1'b0;
        res = '0;
        if (!scan_done) begin
            if (scan_fill >= WinDepth) begin
                sig = {scan_win[3], scan_win[2], scan_win[1], scan_win[0]};
                ofs = {scan_win[7], scan_win[6], scan_win[5], scan_win[4]};
                cnt = {b.data_byte, scan_win[10], scan_win[9], scan_win[8]};
                if (sig == sig_cfg && ofs >= min_ofs_cfg && cnt != 32'd0 &&
                        cnt < cnt_lim_cfg) begin
                    hit                  = 1'b1;
                    res.found            = 1'b1;
                    res.header_offset    = 32'(scan_pos - 64'(WinDepth));
                    res.data_offset_word = ofs;
                    res.file_count_word  = cnt;
                    scan_done            = 1'b1;
                end
            end
            if (!scan_done) begin
                for (int i = 0; i < WinDepth - 1; i++) scan_win[i] = scan_win[i + 1];
                scan_win[WinDepth - 1] = b.data_byte;
                if (scan_fill < WinDepth) scan_fill++;
                if (scan_pos < PosMax) scan_pos++;
            end
            // The stream ended without a header.
            if (b.last_byte && !scan_done) begin
                hit = 1'b1;
                res = '0;
            end
        end
        if (b.last_byte) begin
            foreach (scan_win[i]) scan_win[i] = 8'h00;
            scan_fill = 0;
            scan_pos  = '0;
            scan_done = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        // Keep the log short when a fault repeats on every result.
        if (mismatch_count <= ReportCap)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Predict on every accepted byte first, then check any accepted result.
    always @(posedge i_clk) begin : result_check
        logic      hit;
        t_out_item predicted;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                locate_step(i_in_data, hit, predicted);
                if (row_from_table) locate_results_due.push_back(row_result);
                else if (hit) locate_results_due.push_back(predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (locate_results_due.size() == 0) begin
                    report_mismatch("result with none due, offset",
                                    o_out_data.header_offset, 32'h0);
                end else begin
                    want = locate_results_due.pop_front();
                    if (o_out_data.found != want.found)
                        report_mismatch("found", 32'(o_out_data.found), 32'(want.found));
                    if (o_out_data.header_offset != want.header_offset)
                        report_mismatch("header_offset", o_out_data.header_offset,
                                        want.header_offset);
                    if (o_out_data.data_offset_word != want.data_offset_word)
                        report_mismatch("data_offset_word", o_out_data.data_offset_word,
                                        want.data_offset_word);
                    if (o_out_data.file_count_word != want.file_count_word)
                        report_mismatch("file_count_word", o_out_data.file_count_word,
                                        want.file_count_word);
                end
            end
        end
    end

    // Watchdog: give up when no transaction completes on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("archive_header_locator: mismatch");
            $finish;
        end
    end

    // Result receiver: random stalls, or one long hold-off when asked for.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one byte, idling first at random, and return at the falling edge
    // after the transaction completes.
    task automatic send_item(input t_in_item b, input logic from_table,
                             input t_out_item res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        row_from_table = from_table;
        row_result     = res;
        i_in_valid    <= 1'b1;
        i_in_data     <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        t_in_item item;
        item.data_byte = b;
        item.last_byte = 1'b0;
        stream_q.push_back(item);
    endfunction

    function automatic void put_noise(input int unsigned n);
        repeat (n) put_byte(8'($urandom));
    endfunction

    function automatic void put_word(input logic [31:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
        put_byte(w[23:16]);
        put_byte(w[31:24]);
    endfunction

    function automatic void put_header(input logic [31:0] sig, input logic [31:0] ofs,
                                       input logic [31:0] cnt);
        put_word(sig);
        put_word(ofs);
        put_word(cnt);
    endfunction

    // A header passing the current settings if any count can; words often at bounds.
    function automatic void put_valid_header();
        logic [31:0] ofs;
        logic [31:0] cnt;
        logic [31:0] step;
        step = 32'($urandom_range(255));
        case ($urandom_range(3))
            0: ofs = min_ofs_cfg;
            1: ofs = 32'hFFFF_FFFF;
            2: ofs = (min_ofs_cfg + step < min_ofs_cfg) ? 32'hFFFF_FFFF : min_ofs_cfg + step;
            default: begin
                ofs = $urandom;
                if (ofs < min_ofs_cfg) ofs = min_ofs_cfg;
            end
        endcase
        // With a limit below two no count is valid; any value will do.
        if (cnt_lim_cfg < 32'd2) begin
            cnt = $urandom;
        end else begin
            case ($urandom_range(2))
                0: cnt = 32'd1;
                1: cnt = cnt_lim_cfg - 32'd1;
                default: cnt = 32'd1 + $urandom % (cnt_lim_cfg - 32'd1);
            endcase
        end
        put_header(sig_cfg, ofs, cnt);
    endfunction

    // Mark the final byte of the built stream and send it.
    task automatic send_stream();
        stream_q[stream_q.size() - 1].last_byte = 1'b1;
        foreach (stream_q[k]) send_item(stream_q[k], ByModel, NoResult);
        round_items += stream_q.size();
        stream_q.delete();
    endtask

    // Stop offering, wait for every due result, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (locate_results_due.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CfgSignature: sig_cfg     = value;
            CfgMinOffset: min_ofs_cfg = value;
            CfgCountLim:  cnt_lim_cfg = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Register settings, extremes among them; the unused index must be ignored.
    task automatic apply_setting(input int unsigned k);
        logic [31:0] sig;
        logic [31:0] ofs;
        logic [31:0] lim;
        case (k % 6)
            0: begin
                sig = SignatureReset;
                ofs = MinOffsetReset;
                lim = CountLimReset;
            end
            1: begin
                sig = $urandom;
                ofs = 32'h0;
                lim = 32'hFFFF_FFFF;
            end
            2: begin
                sig = 32'hFFFF_FFFF;
                ofs = 32'hFFFF_FFFF;
                lim = 32'h1;
            end
            3: begin
                // A zero count limit rejects every header.
                sig = 32'h0;
                ofs = 32'($urandom_range(255));
                lim = 32'h0;
            end
            4: begin
                sig = $urandom;
                ofs = $urandom;
                lim = $urandom;
            end
            default: begin
                sig = 32'h0;
                ofs = 32'h0;
                lim = 32'h2;
            end
        endcase
        write_reg(CfgSignature, sig);
        write_reg(CfgMinOffset, ofs);
        write_reg(CfgCountLim, lim);
        write_reg(CfgUnused, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // One setting, then random streams: mostly well-formed headers, some broken
    // ones and some plain noise.
    task automatic run_round(input int unsigned k);
        int unsigned kind;
        logic [31:0] sig;
        logic [31:0] ofs;
        logic [31:0] cnt;
        logic        cut;
        drain();
        apply_setting(k);
        round_items = 0;
        while (round_items < RoundItems) begin
            kind = $urandom_range(99);
            put_noise($urandom_range(6));
            if (kind < 60) begin
                put_valid_header();
                // A second header must never be reported.
                if ($urandom_range(3) == 0) put_valid_header();
            end else if (kind < 80) begin
                sig = sig_cfg;
                ofs = min_ofs_cfg;
                cnt = 32'd1;
                cut = 1'b0;
                case ($urandom_range(4))
                    0: sig = sig_cfg ^ (32'd1 << $urandom_range(31));
                    1: ofs = min_ofs_cfg - 32'd1;
                    2: cnt = 32'd0;
                    3: cnt = cnt_lim_cfg;
                    default: cut = 1'b1;
                endcase
                put_header(sig, ofs, cnt);
                if (cut) repeat ($urandom_range(1, 11)) void'(stream_q.pop_back());
                if ($urandom_range(1) == 1) put_valid_header();
            end else begin
                put_noise($urandom_range(1, 24));
            end
            put_noise($urandom_range(4));
            if (stream_q.size() == 0) put_noise(1);
            send_stream();
        end
    endtask

    initial begin : stimulus
        t_in_item    b;
        int unsigned round_no;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        foreach (scan_win[i]) scan_win[i] = 8'h00;
        round_no = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles rarely, receiver often.
        send_idle_pct = 13;
        recv_idle_pct = 62;
        foreach (DirTable[r]) begin
            b.data_byte = DirTable[r].data_byte;
            b.last_byte = DirTable[r].last_byte;
            send_item(b, DirTable[r].from_table, DirTable[r].result);
        end
        repeat (4) begin
            round_no++;
            run_round(round_no);
        end

        // Sender idles often, receiver rarely.
        send_idle_pct = 62;
        recv_idle_pct = 13;
        repeat (4) begin
            round_no++;
            run_round(round_no);
        end

        // No idling. First fill the block behind a long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        apply_setting(0);
        hold_req = 1'b1;
        repeat (12) begin
            put_noise(1);
            send_stream();
        end
        put_valid_header();
        send_stream();
        repeat (4) begin
            round_no++;
            run_round(round_no);
        end

        drain();
        if (mismatch_count == 0) begin
            $display("archive_header_locator: match");
        end else begin
            $display("archive_header_locator: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ahl_pkg.sv
hdl/ahl_scan.sv
hdl/archive_header_locator.sv
tb/sv/tb_archive_header_locator.sv
